>>> sv/uas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uas_pkg
// shared widths, types and helpers of the upwind advection stencil
// ----------------------------------------------------------------------------
package uas_pkg;

   localparam int MAX_EDGE       = 64;
   localparam int VALUE_BITS     = 32;
   localparam int COURANT_BITS   = 18;
   localparam int EDGE_BITS      = 7;
   localparam int ROW_BITS       = EDGE_BITS + 1;
   localparam int FRAC_BITS      = 16;
   localparam int DELAY_DEPTH    = 2 * (MAX_EDGE + 2) * (MAX_EDGE + 2) + 1;
   localparam int ADDR_BITS      = $clog2(DELAY_DEPTH);
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = COURANT_BITS;
   localparam int DIFF_BITS      = VALUE_BITS + 1;
   localparam int PROD_BITS      = COURANT_BITS + DIFF_BITS;
   localparam int SUM_BITS       = PROD_BITS + 2;
   localparam int QUO_BITS       = SUM_BITS - FRAC_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CELLS_X   = 3'd0,
      CSR_CELLS_Y   = 3'd1,
      CSR_CELLS_Z   = 3'd2,
      CSR_COURANT_X = 3'd3,
      CSR_COURANT_Y = 3'd4,
      CSR_COURANT_Z = 3'd5
   } csr_index_type;

   typedef logic signed [VALUE_BITS-1:0]   value_type;
   typedef logic signed [COURANT_BITS-1:0] courant_type;
   typedef logic [ADDR_BITS-1:0]           addr_type;
   typedef logic [EDGE_BITS-1:0]           edge_type;

   // tap distances behind the newest word
   typedef struct packed {
      addr_type u;
      addr_type xm;
      addr_type xp;
      addr_type ym;
      addr_type yp;
      addr_type zm;
   } dist_type;

   // centre and neighbor words of one stencil
   typedef struct packed {
      value_type u;
      value_type xm;
      value_type xp;
      value_type ym;
      value_type yp;
      value_type zm;
      value_type zp;
   } taps_type;

   // edge of 0 acts as 1, above max acts as max
   function automatic edge_type edge_clamp(edge_type raw);
      edge_type e;
      e = raw;
      if (raw == '0) begin
         e = edge_type'(1);
      end else if (raw > edge_type'(MAX_EDGE)) begin
         e = edge_type'(MAX_EDGE);
      end
      return e;
   endfunction

endpackage

>>> sv/uas_tap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uas_tap_ram
// one write port, two registered read ports, delay line depth
// ----------------------------------------------------------------------------
module uas_tap_ram (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [uas_pkg::ADDR_BITS-1:0]  wr_addr,
   input  logic [uas_pkg::VALUE_BITS-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [uas_pkg::ADDR_BITS-1:0]  rd_addr_a,
   input  logic [uas_pkg::ADDR_BITS-1:0]  rd_addr_b,
   output logic [uas_pkg::VALUE_BITS-1:0] rd_data_a,
   output logic [uas_pkg::VALUE_BITS-1:0] rd_data_b
);
   import uas_pkg::*;

   logic [VALUE_BITS-1:0] mem_ff [DELAY_DEPTH];
   logic [VALUE_BITS-1:0] rd_a_ff;
   logic [VALUE_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> sv/uas_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uas_window
// circular delay line of two planes plus one word, six read taps plus the newest word
// ----------------------------------------------------------------------------
module uas_window (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  uas_pkg::value_type    wr_data,
   input  uas_pkg::dist_type     tap_dist,
   output uas_pkg::taps_type     taps
);
   import uas_pkg::*;

   addr_type  wp_ff;
   addr_type  wp_in;
   addr_type  wp_next;
   value_type newest_ff;
   addr_type  addr_u, addr_xm, addr_xp, addr_ym, addr_yp, addr_zm;
   logic [VALUE_BITS-1:0] q_u, q_xm, q_xp, q_ym, q_yp, q_zm;

   // address d words behind the slot being written
   function automatic addr_type back_addr(addr_type wp, addr_type d);
      logic [ADDR_BITS:0] diff;
      logic [ADDR_BITS:0] wrap;
      diff = {1'b0, wp} - {1'b0, d};
      wrap = {1'b0, wp} + (ADDR_BITS+1)'(DELAY_DEPTH) - {1'b0, d};
      return diff[ADDR_BITS] ? wrap[ADDR_BITS-1:0] : diff[ADDR_BITS-1:0];
   endfunction

   assign wp_next = (wp_ff == addr_type'(DELAY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign wp_in   = shift_en ? wp_next : wp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         newest_ff <= wr_data;
      end
   end

   assign addr_u  = back_addr(wp_next, tap_dist.u);
   assign addr_xm = back_addr(wp_next, tap_dist.xm);
   assign addr_xp = back_addr(wp_next, tap_dist.xp);
   assign addr_ym = back_addr(wp_next, tap_dist.ym);
   assign addr_yp = back_addr(wp_next, tap_dist.yp);
   assign addr_zm = back_addr(wp_next, tap_dist.zm);

   // three copies of the line, same writes, two reads each
   uas_tap_ram u_ram_0 (
      .clock     (clock),
      .wr_en     (shift_en),
      .wr_addr   (wp_next),
      .wr_data   (wr_data),
      .rd_en     (shift_en),
      .rd_addr_a (addr_u),
      .rd_addr_b (addr_xm),
      .rd_data_a (q_u),
      .rd_data_b (q_xm)
   );

   uas_tap_ram u_ram_1 (
      .clock     (clock),
      .wr_en     (shift_en),
      .wr_addr   (wp_next),
      .wr_data   (wr_data),
      .rd_en     (shift_en),
      .rd_addr_a (addr_xp),
      .rd_addr_b (addr_ym),
      .rd_data_a (q_xp),
      .rd_data_b (q_ym)
   );

   uas_tap_ram u_ram_2 (
      .clock     (clock),
      .wr_en     (shift_en),
      .wr_addr   (wp_next),
      .wr_data   (wr_data),
      .rd_en     (shift_en),
      .rd_addr_a (addr_yp),
      .rd_addr_b (addr_zm),
      .rd_data_a (q_yp),
      .rd_data_b (q_zm)
   );

   assign taps.u  = value_type'(q_u);
   assign taps.xm = value_type'(q_xm);
   assign taps.xp = value_type'(q_xp);
   assign taps.ym = value_type'(q_ym);
   assign taps.yp = value_type'(q_yp);
   assign taps.zm = value_type'(q_zm);
   assign taps.zp = newest_ff;

endmodule

>>> sv/uas_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uas_update
// upwind differences, courant products, rounding and saturation
// ----------------------------------------------------------------------------
module uas_update (
   input  logic                  clock,
   input  logic                  load,
   input  uas_pkg::taps_type     taps,
   input  uas_pkg::courant_type  courant_x,
   input  uas_pkg::courant_type  courant_y,
   input  uas_pkg::courant_type  courant_z,
   output uas_pkg::value_type    new_value
);
   import uas_pkg::*;

   logic signed [PROD_BITS-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [PROD_BITS-1:0] prod_x_in, prod_y_in, prod_z_in;
   value_type                   u_ff;
   logic signed [SUM_BITS-1:0]  total;
   logic signed [SUM_BITS-1:0]  shifted;
   logic signed [QUO_BITS-1:0]  quo;
   logic                        over_hi;
   logic                        over_lo;

   // backward difference for c >= 0, forward difference otherwise
   function automatic logic signed [PROD_BITS-1:0] axis_product(
      courant_type c, value_type u, value_type lo, value_type hi);
      logic signed [DIFF_BITS-1:0] diff;
      if (c[COURANT_BITS-1]) begin
         diff = DIFF_BITS'(hi) - DIFF_BITS'(u);
      end else begin
         diff = DIFF_BITS'(u) - DIFF_BITS'(lo);
      end
      return PROD_BITS'(c) * PROD_BITS'(diff);
   endfunction

   assign prod_x_in = axis_product(courant_x, taps.u, taps.xm, taps.xp);
   assign prod_y_in = axis_product(courant_y, taps.u, taps.ym, taps.yp);
   assign prod_z_in = axis_product(courant_z, taps.u, taps.zm, taps.zp);

   always_ff @(posedge clock) begin
      if (load) begin
         u_ff      <= taps.u;
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
   end

   // u scaled to q16, minus the three terms, plus one half
   always_comb begin
      total = (SUM_BITS'(u_ff) <<< FRAC_BITS)
            - SUM_BITS'(prod_x_ff) - SUM_BITS'(prod_y_ff) - SUM_BITS'(prod_z_ff)
            + (SUM_BITS'(1) <<< (FRAC_BITS - 1));
      shifted = total >>> FRAC_BITS;
      quo     = shifted[QUO_BITS-1:0];
      over_hi = !quo[QUO_BITS-1] && (|quo[QUO_BITS-2:VALUE_BITS-1]);
      over_lo = quo[QUO_BITS-1] && !(&quo[QUO_BITS-2:VALUE_BITS-1]);
      if (over_hi) begin
         new_value = {1'b0, {(VALUE_BITS-1){1'b1}}};
      end else if (over_lo) begin
         new_value = {1'b1, {(VALUE_BITS-1){1'b0}}};
      end else begin
         new_value = quo[VALUE_BITS-1:0];
      end
   end

endmodule

>>> sv/upwind_advection_stencil_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upwind_advection_stencil_3d
// first-order upwind advection update over a streamed halo-padded 3d block
// ----------------------------------------------------------------------------
// Feed the padded block, (cells_x+2) x (cells_y+2) x (cells_z+2) Q8.24 words,
// in raster order with x fastest; every interior cell comes back as one
// saturated Q8.24 word once the word one padded plane past it has gone in,
// with tlast on the last interior cell of the block. Halo words give no
// result. The block takes one word per clock cycle when the result side keeps
// up. Each result goes through the tap read of the delay line (three copies
// of a 8713-word memory, two registered reads each), one register of courant
// products and the result register. The delay line is not cleared after
// reset, so the block accepts words right away. Write the edges and courant
// numbers only while the stream is idle; a change of the edges in the middle
// of a block keeps the raster position counters where they are.
// ----------------------------------------------------------------------------
module upwind_advection_stencil_3d (
   input  logic                                 clock,
   input  logic                                 reset,
   // input stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [31:0]                          req_tdata,   // [31:0] cell_value
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,   // [31:0] new_value
   output logic                                 rsp_tlast,   // block_done
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [uas_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [uas_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import uas_pkg::*;

   // register file, raw values as written
   edge_type    cells_x_ff, cells_y_ff, cells_z_ff;
   edge_type    cells_x_in, cells_y_in, cells_z_in;
   courant_type courant_x_ff, courant_y_ff, courant_z_ff;
   courant_type courant_x_in, courant_y_in, courant_z_in;

   // clamped edges and tap distances, updated on the same edge as the registers
   edge_type    edge_x_ff, edge_y_ff, edge_z_ff;
   edge_type    edge_x_in, edge_y_in, edge_z_in;
   dist_type    dist_ff, dist_in;
   logic [ROW_BITS-1:0]   row_len;
   logic [ROW_BITS-1:0]   col_len;
   logic [2*ROW_BITS-1:0] plane_full;
   addr_type              plane_len;

   // padded raster position of the next word
   edge_type    pos_x_ff, pos_y_ff, pos_z_ff;
   edge_type    pos_x_in, pos_y_in, pos_z_in;
   logic        wrap_x, wrap_y, wrap_z;
   logic        emit;
   logic        last_cell;

   // pipeline control
   logic        accept, csr_write;
   logic        out_free, s2_adv, s1_adv, s1_move, s2_move;
   logic        s1_v_ff, s1_v_in, s1_last_ff;
   logic        s2_v_ff, s2_v_in, s2_last_ff;
   taps_type    taps;
   value_type   new_value;

   logic        rsp_tvalid_ff;
   logic [31:0] rsp_tdata_ff;
   logic        rsp_tlast_ff;

   // ---------------------------------------------------------------- registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cells_x_in   = cells_x_ff;
      cells_y_in   = cells_y_ff;
      cells_z_in   = cells_z_ff;
      courant_x_in = courant_x_ff;
      courant_y_in = courant_y_ff;
      courant_z_in = courant_z_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_CELLS_X:   cells_x_in   = csr_data[EDGE_BITS-1:0];
            CSR_CELLS_Y:   cells_y_in   = csr_data[EDGE_BITS-1:0];
            CSR_CELLS_Z:   cells_z_in   = csr_data[EDGE_BITS-1:0];
            CSR_COURANT_X: courant_x_in = csr_data;
            CSR_COURANT_Y: courant_y_in = csr_data;
            CSR_COURANT_Z: courant_z_in = csr_data;
            default: ;  // unused indexes are dropped
         endcase
      end
   end

   // padded row and plane lengths from the next register values
   always_comb begin
      edge_x_in  = edge_clamp(cells_x_in);
      edge_y_in  = edge_clamp(cells_y_in);
      edge_z_in  = edge_clamp(cells_z_in);
      row_len    = ROW_BITS'(edge_x_in) + ROW_BITS'(2);
      col_len    = ROW_BITS'(edge_y_in) + ROW_BITS'(2);
      plane_full = row_len * col_len;
      plane_len  = plane_full[ADDR_BITS-1:0];
      dist_in.u  = plane_len;
      dist_in.xm = plane_len + addr_type'(1);
      dist_in.xp = plane_len - addr_type'(1);
      dist_in.ym = plane_len + addr_type'(row_len);
      dist_in.yp = plane_len - addr_type'(row_len);
      dist_in.zm = plane_len << 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff   <= edge_type'(MAX_EDGE);
         cells_y_ff   <= edge_type'(MAX_EDGE);
         cells_z_ff   <= edge_type'(MAX_EDGE);
         courant_x_ff <= '0;
         courant_y_ff <= '0;
         courant_z_ff <= '0;
         edge_x_ff    <= edge_type'(MAX_EDGE);
         edge_y_ff    <= edge_type'(MAX_EDGE);
         edge_z_ff    <= edge_type'(MAX_EDGE);
         dist_ff.u    <= addr_type'((MAX_EDGE + 2) * (MAX_EDGE + 2));
         dist_ff.xm   <= addr_type'((MAX_EDGE + 2) * (MAX_EDGE + 2) + 1);
         dist_ff.xp   <= addr_type'((MAX_EDGE + 2) * (MAX_EDGE + 2) - 1);
         dist_ff.ym   <= addr_type'((MAX_EDGE + 2) * (MAX_EDGE + 3));
         dist_ff.yp   <= addr_type'((MAX_EDGE + 2) * (MAX_EDGE + 1));
         dist_ff.zm   <= addr_type'(2 * (MAX_EDGE + 2) * (MAX_EDGE + 2));
      end else begin
         cells_x_ff   <= cells_x_in;
         cells_y_ff   <= cells_y_in;
         cells_z_ff   <= cells_z_in;
         courant_x_ff <= courant_x_in;
         courant_y_ff <= courant_y_in;
         courant_z_ff <= courant_z_in;
         edge_x_ff    <= edge_x_in;
         edge_y_ff    <= edge_y_in;
         edge_z_ff    <= edge_z_in;
         dist_ff      <= dist_in;
      end
   end

   // ---------------------------------------------------------------- raster position
   // interior centre lags the input by one padded plane, hence z from 2 to nz+1
   always_comb begin
      emit = (pos_x_ff >= edge_type'(1)) && (pos_x_ff <= edge_x_ff)
          && (pos_y_ff >= edge_type'(1)) && (pos_y_ff <= edge_y_ff)
          && (pos_z_ff >= edge_type'(2))
          && (ROW_BITS'(pos_z_ff) <= ROW_BITS'(edge_z_ff) + ROW_BITS'(1));
      last_cell = (pos_x_ff == edge_x_ff) && (pos_y_ff == edge_y_ff)
               && (ROW_BITS'(pos_z_ff) == ROW_BITS'(edge_z_ff) + ROW_BITS'(1));
      wrap_x = (ROW_BITS'(pos_x_ff) + ROW_BITS'(1)) >= (ROW_BITS'(edge_x_ff) + ROW_BITS'(2));
      wrap_y = (ROW_BITS'(pos_y_ff) + ROW_BITS'(1)) >= (ROW_BITS'(edge_y_ff) + ROW_BITS'(2));
      wrap_z = (ROW_BITS'(pos_z_ff) + ROW_BITS'(1)) >= (ROW_BITS'(edge_z_ff) + ROW_BITS'(2));
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (accept) begin
         if (!wrap_x) begin
            pos_x_in = pos_x_ff + 1'b1;
         end else begin
            pos_x_in = '0;
            if (!wrap_y) begin
               pos_y_in = pos_y_ff + 1'b1;
            end else begin
               pos_y_in = '0;
               pos_z_in = wrap_z ? '0 : pos_z_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

   // ---------------------------------------------------------------- pipeline control
   // stage 1: taps read from the delay line, stage 2: courant products,
   // then the result register; a stage moves when the one after it has room
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign s2_adv     = !s2_v_ff || out_free;
   assign s1_adv     = !s1_v_ff || s2_adv;
   assign req_tready = s1_adv;
   assign accept     = req_tvalid && s1_adv;
   assign s1_move    = s1_v_ff && s2_adv;
   assign s2_move    = s2_v_ff && out_free;

   always_comb begin
      if (accept) begin
         s1_v_in = emit;
      end else if (s2_adv) begin
         s1_v_in = 1'b0;
      end else begin
         s1_v_in = s1_v_ff;
      end
      if (s1_move) begin
         s2_v_in = 1'b1;
      end else if (out_free) begin
         s2_v_in = 1'b0;
      end else begin
         s2_v_in = s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         if (s2_move) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff <= last_cell;
      end
      if (s1_move) begin
         s2_last_ff <= s1_last_ff;
      end
      if (s2_move) begin
         rsp_tdata_ff <= new_value;
         rsp_tlast_ff <= s2_last_ff;
      end
   end

   // ---------------------------------------------------------------- datapath
   uas_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .wr_data  (value_type'(req_tdata)),
      .tap_dist (dist_ff),
      .taps     (taps)
   );

   uas_update u_update (
      .clock     (clock),
      .load      (s1_move),
      .taps      (taps),
      .courant_x (courant_x_ff),
      .courant_y (courant_y_ff),
      .courant_z (courant_z_ff),
      .new_value (new_value)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   // input stalls only with every stage full and the result side stalled
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_v_ff && s2_v_ff && rsp_tvalid && !rsp_tready))
      else $error("input stalled with room in the pipeline");

   // an interior centre always enters stage 1
   a_emit_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> s1_v_ff)
      else $error("interior word lost at stage 1");

   // stalled products keep their flag
   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && !out_free) |=> (s2_v_ff && $stable(s2_last_ff)))
      else $error("stage 2 changed while stalled");

   // tap distances stay consistent with one plane
   a_dist_consistent: assert property (@(posedge clock) disable iff (reset)
      (dist_ff.zm == (dist_ff.u << 1)) && (dist_ff.xm == dist_ff.u + addr_type'(1)))
      else $error("tap distances out of step");
`endif

endmodule

>>> tb/sv/upwind_update_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upwind_update_checker
// follows register writes and accepted cell words, predicts each upwind
// update and compares it with the words leaving the result stream
// ----------------------------------------------------------------------------
module upwind_update_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [31:0]                          req_tdata,   // [31:0] cell_value
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [31:0]                          rsp_tdata,   // [31:0] new_value
   input  logic                                 rsp_tlast,   // block_done
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [uas_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [uas_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output int                                   fail_count,
   output int                                   open_count
);
   import uas_pkg::*;

   typedef struct packed {
      value_type new_value;
      logic      block_done;
   } update_type;

   localparam longint VALUE_MAX = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
   localparam longint VALUE_MIN = -VALUE_MAX - 1;

   logic [VALUE_BITS-1:0] cell_history [DELAY_DEPTH];
   int                    hist_ptr;
   int                    pos_x, pos_y, pos_z;
   edge_type              edge_reg [3];
   courant_type           courant_reg [3];
   update_type            pending_updates [$];
   int                    mismatches = 0;

   // zero acts as one, anything above the largest edge as the largest edge
   function automatic int interior_span(edge_type raw);
      int n;
      n = int'(raw);
      if (n < 1) begin
         n = 1;
      end else if (n > MAX_EDGE) begin
         n = MAX_EDGE;
      end
      return n;
   endfunction

   // word d places behind the newest one
   function automatic longint history_tap(int d);
      int idx;
      idx = (hist_ptr + DELAY_DEPTH - (d % DELAY_DEPTH)) % DELAY_DEPTH;
      return longint'(signed'(cell_history[idx]));
   endfunction

   // courant times the upwind difference along one axis
   function automatic longint upwind_flux(courant_type c, longint u, int d_low, int d_high);
      longint diff;
      if (c >= 0) begin
         diff = u - history_tap(d_low);
      end else begin
         diff = history_tap(d_high) - u;
      end
      return longint'(c) * diff;
   endfunction

   task automatic predict_update(value_type word);
      int         nx, ny, nz, row, plane;
      longint     u, sum, t, q;
      update_type upd;
      nx    = interior_span(edge_reg[0]);
      ny    = interior_span(edge_reg[1]);
      nz    = interior_span(edge_reg[2]);
      row   = nx + 2;
      plane = row * (ny + 2);
      hist_ptr = (hist_ptr + 1) % DELAY_DEPTH;
      cell_history[hist_ptr] = word;
      if (pos_x >= 1 && pos_x <= nx && pos_y >= 1 && pos_y <= ny &&
          pos_z >= 2 && pos_z <= nz + 1) begin
         u   = history_tap(plane);
         sum = upwind_flux(courant_reg[0], u, plane + 1, plane - 1)
             + upwind_flux(courant_reg[1], u, plane + row, plane - row)
             + upwind_flux(courant_reg[2], u, 2 * plane, 0);
         // round half up, then floor back to the value scale
         t = (u <<< FRAC_BITS) - sum + (longint'(1) <<< (FRAC_BITS - 1));
         q = t >>> FRAC_BITS;
         if (q > VALUE_MAX) begin
            q = VALUE_MAX;
         end else if (q < VALUE_MIN) begin
            q = VALUE_MIN;
         end
         upd.new_value  = value_type'(q);
         upd.block_done = (pos_x == nx && pos_y == ny && pos_z == nz + 1);
         pending_updates.push_back(upd);
      end
      pos_x++;
      if (pos_x >= nx + 2) begin
         pos_x = 0;
         pos_y++;
         if (pos_y >= ny + 2) begin
            pos_y = 0;
            pos_z++;
            if (pos_z >= nz + 2) begin
               pos_z = 0;
            end
         end
      end
   endtask

   task automatic check_update(value_type got_value, logic got_done);
      update_type upd;
      if (pending_updates.size() == 0) begin
         $error("update %0d arrived with none outstanding", got_value);
         mismatches++;
      end else begin
         upd = pending_updates.pop_front();
         if (got_value !== upd.new_value) begin
            $error("new_value: expected %0d, got %0d", upd.new_value, got_value);
            mismatches++;
         end
         if (got_done !== upd.block_done) begin
            $error("block_done: expected %0d, got %0d", upd.block_done, got_done);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hist_ptr = 0;
         pos_x    = 0;
         pos_y    = 0;
         pos_z    = 0;
         for (int i = 0; i < 3; i++) begin
            edge_reg[i]    = edge_type'(MAX_EDGE);
            courant_reg[i] = '0;
         end
         pending_updates.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CELLS_X:   edge_reg[0]    = csr_data[EDGE_BITS-1:0];
               CSR_CELLS_Y:   edge_reg[1]    = csr_data[EDGE_BITS-1:0];
               CSR_CELLS_Z:   edge_reg[2]    = csr_data[EDGE_BITS-1:0];
               CSR_COURANT_X: courant_reg[0] = courant_type'(csr_data);
               CSR_COURANT_Y: courant_reg[1] = courant_type'(csr_data);
               CSR_COURANT_Z: courant_reg[2] = courant_type'(csr_data);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_update(value_type'(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            check_update(value_type'(rsp_tdata), rsp_tlast);
         end
      end
      fail_count <= mismatches;
      open_count <= pending_updates.size();
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// regression of the upwind advection stencil: streams padded blocks of many
// shapes and courant settings, mostly under random source gaps and sink stalls,
// with a checker beside the block predicting every update
// ----------------------------------------------------------------------------
module tb;
   import uas_pkg::*;

   // hold-off after the last expected update; lets the pipeline work through
   // trailing halo words
   localparam int TAIL_CYCLES     = 12;
   localparam int CYCLE_LIMIT     = 400000;
   // words of small random blocks streamed in each phase, at the least
   localparam int PHASE_WORDS     = 100;
   // register index with no register behind it
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 3'd6;
   localparam courant_type COURANT_ONE = courant_type'(1 << FRAC_BITS);
   // most negative courant, -2.0
   localparam courant_type COURANT_MIN = courant_type'(1 << (COURANT_BITS - 1));
   localparam value_type VALUE_MAX = value_type'({1'b0, {(VALUE_BITS-1){1'b1}}});
   localparam value_type VALUE_MIN = value_type'({1'b1, {(VALUE_BITS-1){1'b0}}});

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic [31:0]                 req_tdata  = '0;   // [31:0] cell_value
   logic                        rsp_tready = 1'b0;
   logic                        csr_valid  = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]    csr_data   = '0;
   logic                        req_tready;
   logic                        rsp_tvalid;
   logic [31:0]                 rsp_tdata;         // [31:0] new_value
   logic                        rsp_tlast;         // block_done
   logic                        csr_ready;

   int fail_count;
   int open_count;
   int cycle_count;
   int gap_pct   = 15;
   int stall_pct = 67;
   int words_sent = 0;
   // raster position of the next word and the interior edges now in force
   int ras_x = 0, ras_y = 0, ras_z = 0;
   int edge_eff [3] = '{MAX_EDGE, MAX_EDGE, MAX_EDGE};

   upwind_advection_stencil_3d dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   upwind_update_checker update_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("upwind_advection_stencil_3d regression: fail");
      $finish;
   end

   // sink stalls, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // edge register as the block sees it: zero acts as one, large values clip
   function automatic int edge_in_force(edge_type raw);
      int n;
      n = int'(raw);
      if (n == 0) begin
         n = 1;
      end else if (n > MAX_EDGE) begin
         n = MAX_EDGE;
      end
      return n;
   endfunction

   // extremes, small integers, values near the Q8.24 unit and full-range noise
   function automatic value_type pick_value();
      value_type v;
      case ($urandom_range(9))
         0: v = VALUE_MAX;
         1: v = VALUE_MIN;
         2: v = '0;
         3: v = value_type'(int'($urandom_range(0, 8)) - 4);
         4, 5: v = value_type'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
         default: v = value_type'($urandom);
      endcase
      return v;
   endfunction

   // half steps make rounding ties; full random reaches past +-1.0
   function automatic courant_type pick_courant();
      courant_type c;
      case ($urandom_range(7))
         0: c = '0;
         1: c = COURANT_ONE;
         2: c = -COURANT_ONE;
         3: c = COURANT_ONE >>> 1;
         4: c = -(COURANT_ONE >>> 1);
         5: c = courant_type'($urandom);
         default: c = courant_type'(int'($urandom_range(0, 2 << FRAC_BITS)) - (1 << FRAC_BITS));
      endcase
      return c;
   endfunction

   // small edges keep blocks short; zero exercises the clamp to one
   function automatic edge_type pick_edge();
      return edge_type'($urandom_range(0, 4));
   endfunction

   // valid is left high so back-to-back writes need no gap
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // edges carry random upper bits, which the block must ignore
   task automatic load_config(edge_type ex, edge_type ey, edge_type ez,
                              courant_type cx, courant_type cy, courant_type cz);
      write_reg(CSR_CELLS_X, {(CSR_DATA_BITS-EDGE_BITS)'($urandom), ex});
      write_reg(CSR_CELLS_Y, {(CSR_DATA_BITS-EDGE_BITS)'($urandom), ey});
      write_reg(CSR_CELLS_Z, {(CSR_DATA_BITS-EDGE_BITS)'($urandom), ez});
      write_reg(CSR_COURANT_X, cx);
      write_reg(CSR_COURANT_Y, cy);
      write_reg(CSR_COURANT_Z, cz);
      csr_valid <= 1'b0;
      edge_eff[0] = edge_in_force(ex);
      edge_eff[1] = edge_in_force(ey);
      edge_eff[2] = edge_in_force(ez);
   endtask

   task automatic load_random_config();
      load_config(pick_edge(), pick_edge(), pick_edge(),
                  pick_courant(), pick_courant(), pick_courant());
   endtask

   // one word with an optional source gap ahead of it
   task automatic send_word(value_type word);
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      ras_x++;
      if (ras_x >= edge_eff[0] + 2) begin
         ras_x = 0;
         ras_y++;
         if (ras_y >= edge_eff[1] + 2) begin
            ras_y = 0;
            ras_z++;
            if (ras_z >= edge_eff[2] + 2) begin
               ras_z = 0;
            end
         end
      end
   endtask

   // stream words until the raster position is back at the block origin
   task automatic finish_block();
      do send_word(pick_value()); while (ras_x != 0 || ras_y != 0 || ras_z != 0);
   endtask

   // drain: every update seen, then let trailing halo words clear the pipe
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      value_type burst [27];
      int        phase_start;
      int        block_words;
      bit        split_done;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed block: all edges zero act as one, so a padded 3x3x3 block
      // with one interior cell; x runs backward at +1.0, y forward at -1.0,
      // z forward at -2.0, and the centre is built to saturate high
      write_reg(CSR_SPARE_INDEX, CSR_DATA_BITS'($urandom));
      load_config(7'd0, 7'd0, 7'd0, COURANT_ONE, -COURANT_ONE, COURANT_MIN);
      for (int i = 0; i < 27; i++) begin
         case (i % 5)
            0: burst[i] = VALUE_MAX;
            1: burst[i] = VALUE_MIN;
            2: burst[i] = '0;
            3: burst[i] = '1;
            default: burst[i] = value_type'(1);
         endcase
      end
      burst[13] = VALUE_MIN;   // centre
      burst[12] = VALUE_MAX;   // lower x neighbor
      burst[16] = VALUE_MAX;   // upper y neighbor
      burst[22] = VALUE_MAX;   // upper z neighbor
      for (int i = 0; i < 27; i++) begin
         send_word(burst[i]);
      end

      // three idle mixes: sink-bound, source-bound, then full rate
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               gap_pct   = 15;
               stall_pct = 67;
            end
            1: begin
               gap_pct   = 67;
               stall_pct = 15;
            end
            default: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
         endcase
         wait_idle();

         // the full-rate phase streams one thin block whose row runs the
         // full edge; 127 on x and 0 on y check the clamps
         if (phase == 2) begin
            load_config(7'd127, 7'd0, 7'd1, pick_courant(), pick_courant(), pick_courant());
            finish_block();
         end

         phase_start = words_sent;
         split_done  = 1'b0;
         while (words_sent - phase_start < PHASE_WORDS) begin
            if ($urandom_range(2) == 0) begin
               wait_idle();
               load_random_config();
            end
            if (!split_done && words_sent - phase_start >= PHASE_WORDS / 2) begin
               // edges changed in the middle of a block: the position carries
               // over; the new edges are small, so every tap lands on a word
               // streamed since reset
               block_words = (edge_eff[0] + 2) * (edge_eff[1] + 2) * (edge_eff[2] + 2);
               repeat ($urandom_range(1, block_words - 1)) send_word(pick_value());
               wait_idle();
               load_random_config();
               while (ras_x != 0 || ras_y != 0 || ras_z != 0) begin
                  send_word(pick_value());
               end
               split_done = 1'b1;
            end else begin
               finish_block();
            end
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("upwind_advection_stencil_3d regression: pass");
      end else begin
         $display("upwind_advection_stencil_3d regression: fail");
      end
      $finish;
   end

endmodule
